FILE: hw/rtl/ring_aromaticity_classifier_assert.svh
// Assertion macros for the ring aromaticity classifier
`ifndef RING_AROMATICITY_CLASSIFIER_ASSERT_SVH
`define RING_AROMATICITY_CLASSIFIER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RAC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ring aromaticity classifier: assertion failed");
`define RAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring aromaticity classifier: assertion failed");
`else
`define RAC_ASSERT(lbl, cond)
`define RAC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/rac_pkg.sv
// Shared types and constants for the ring aromaticity classifier
package rac_pkg;

    localparam int unsigned MAX_DEGREE = 15;
    localparam int unsigned CNT_W      = $clog2(MAX_DEGREE + 1);
    localparam int unsigned NB_W       = CNT_W + 1;

    localparam logic [1:0] PI_MASK      = 2'h3;
    localparam logic [2:0] ORDER_SINGLE = 3'd1;
    localparam logic [2:0] ORDER_DOUBLE = 3'd2;

    typedef enum logic [1:0] {
        GRP_CARBON,
        GRP_NITROGEN,
        GRP_OXYGEN,
        GRP_OTHER
    } grp_t;

    typedef enum logic [1:0] {
        SETTLE_OPEN,
        SETTLE_FALSE,
        SETTLE_TRUE
    } settle_t;

    typedef struct packed {
        logic [CNT_W-1:0] single;
        logic [CNT_W-1:0] ring_dbl;
        logic [CNT_W-1:0] exo_dbl;
        logic [CNT_W-1:0] marked;
        logic [CNT_W-1:0] total;
    } atom_cnt_t;

    typedef struct packed {
        logic        present;
        logic [2:0]  order;
        logic        in_ring;
        logic        marked;
        grp_t        group;
        logic [2:0]  hyd;
        logic [3:0]  chg;
        logic        last_bond;
        logic        last_atom;
    } bond_item_t;

    typedef struct packed {
        logic       pi_ok;
        logic [1:0] pi;
        logic       rules_out;
    } atom_verdict_t;

endpackage

FILE: hw/rtl/rac_count.sv
// Per-atom bond counter update for one bond transfer
module rac_count (
    input  rac_pkg::bond_item_t item,
    input  rac_pkg::atom_cnt_t  cnt,
    output rac_pkg::atom_cnt_t  cnt_upd,
    output logic                bad_order
);
    import rac_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEGREE);

    logic order_ok;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    assign order_ok  = (item.order == ORDER_SINGLE) || (item.order == ORDER_DOUBLE);
    assign bad_order = item.present && !order_ok;

    always_comb
    begin
        cnt_upd = cnt;
        if (item.present && order_ok)
        begin
            if (item.order == ORDER_SINGLE)
            begin
                cnt_upd.single = sat_inc(cnt.single);
            end
            else if (item.in_ring)
            begin
                cnt_upd.ring_dbl = sat_inc(cnt.ring_dbl);
            end
            else
            begin
                cnt_upd.exo_dbl = sat_inc(cnt.exo_dbl);
            end
            cnt_upd.total = sat_inc(cnt.total);
            if (item.marked)
            begin
                cnt_upd.marked = sat_inc(cnt.marked);
            end
        end
    end

endmodule

FILE: hw/rtl/rac_rules.sv
// Per-atom pi electron and rule-out decision table
module rac_rules (
    input  rac_pkg::atom_cnt_t    cnt,
    input  rac_pkg::grp_t         group,
    input  logic [2:0]            hyd,
    input  logic [3:0]            chg,
    output rac_pkg::atom_verdict_t verdict
);
    import rac_pkg::*;

    logic [NB_W-1:0] nb;
    logic [NB_W-1:0] ns;
    logic [CNT_W:0]  nd;
    logic            alt;
    logic            nd_one;
    logic            chg_zero;
    logic            chg_pos;
    logic            chg_neg;

    assign nb       = {1'b0, cnt.total} + NB_W'(hyd);
    assign ns       = {1'b0, cnt.single} + NB_W'(hyd);
    assign nd       = {1'b0, cnt.ring_dbl} + {1'b0, cnt.exo_dbl};
    assign nd_one   = (nd == (CNT_W+1)'(1));
    assign alt      = (cnt.ring_dbl == CNT_W'(1)) ||
                      ((cnt.marked != '0) && (cnt.exo_dbl == CNT_W'(1)));
    assign chg_zero = (chg == 4'h0);
    assign chg_pos  = (chg == 4'h1);
    assign chg_neg  = (chg == 4'hF);

    always_comb
    begin
        verdict.pi_ok     = 1'b0;
        verdict.pi        = 2'd0;
        verdict.rules_out = 1'b1;
        case (group)
            GRP_CARBON:
            begin
                if (nb == NB_W'(3))
                begin
                    if (ns == NB_W'(3))
                    begin
                        verdict.pi_ok     = chg_pos || chg_neg;
                        verdict.pi        = chg_neg ? 2'd2 : 2'd0;
                        verdict.rules_out = !(chg_pos || chg_neg);
                    end
                    else if (chg_zero)
                    begin
                        verdict.pi_ok     = (ns == NB_W'(2)) && alt;
                        verdict.pi        = 2'd1;
                        verdict.rules_out = !((ns == NB_W'(2)) && nd_one);
                    end
                end
            end
            GRP_NITROGEN:
            begin
                if (nb == NB_W'(2))
                begin
                    if (ns == NB_W'(2))
                    begin
                        verdict.pi_ok     = chg_neg;
                        verdict.pi        = 2'd2;
                        verdict.rules_out = !chg_neg;
                    end
                    else
                    begin
                        verdict.pi_ok     = (cnt.ring_dbl == CNT_W'(1)) &&
                                            (chg_zero || chg_pos);
                        verdict.pi        = 2'd1;
                        verdict.rules_out = !(nd_one && (chg_zero || chg_pos));
                    end
                end
                else if (nb == NB_W'(3))
                begin
                    if (ns == NB_W'(3))
                    begin
                        verdict.pi_ok     = chg_zero;
                        verdict.pi        = 2'd2;
                        verdict.rules_out = !chg_zero;
                    end
                    else if (chg_pos)
                    begin
                        verdict.pi_ok     = (ns == NB_W'(2)) && alt;
                        verdict.pi        = 2'd1;
                        verdict.rules_out = !((ns == NB_W'(2)) && nd_one);
                    end
                end
            end
            GRP_OXYGEN:
            begin
                verdict.pi_ok     = (nb == NB_W'(2)) && (ns == NB_W'(2)) && chg_zero;
                verdict.pi        = 2'd2;
                verdict.rules_out = !verdict.pi_ok;
            end
            default:
            begin
                verdict.pi_ok     = 1'b0;
                verdict.rules_out = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ring_aromaticity_classifier.sv
// Top level of the ring aromaticity classifier
//
// Bond items arrive on the bond channel (bond_valid / bond_stall), grouped by
// ring atom; last_bond_of_atom closes an atom and, together with
// last_atom_of_ring, closes the ring. Each ring yields one verdict transfer on
// the verdict channel (verdict_valid / verdict_stall) carrying is_aromatic
// and is_not_aromatic; all other items yield nothing.
// An accepted item is held in the input register and evaluated by the
// counter and rule logic; a ring verdict is loaded into the output register
// when the closing item leaves the input register. Throughput is one bond
// item per cycle while bond_stall is low; the per-atom counters, pi parity
// and verdict latches update in the same cycle an item leaves the input
// register. Reset clears all counters, latches and both valid flags.
// While the verdict register is held by verdict_stall, items that give no
// verdict still advance; an item closing the next ring waits in the input
// register and bond_stall rises until the held verdict is taken.
`include "ring_aromaticity_classifier_assert.svh"

module ring_aromaticity_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       bond_valid,
    output logic       bond_stall,
    input  logic       bond_present,
    input  logic [2:0] bond_order,
    input  logic       bond_in_ring,
    input  logic       bond_marked_aromatic,
    input  logic [1:0] atom_group,
    input  logic [2:0] implicit_hydrogens,
    input  logic signed [3:0] formal_charge,
    input  logic       last_bond_of_atom,
    input  logic       last_atom_of_ring,
    output logic       verdict_valid,
    input  logic       verdict_stall,
    output logic       is_aromatic,
    output logic       is_not_aromatic
);
    import rac_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    bond_item_t    item_reg;
    bond_item_t    item_in;
    atom_cnt_t     cnt_reg;
    atom_cnt_t     cnt_next;
    atom_cnt_t     cnt_upd;
    logic [1:0]    pi_reg;
    logic [1:0]    pi_next;
    settle_t       arom_reg;
    settle_t       arom_next;
    settle_t       nonarom_reg;
    settle_t       nonarom_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          arom_out_reg;
    logic          nonarom_out_reg;
    logic          bad_order;
    atom_verdict_t verdict;
    settle_t       arom_chk;
    settle_t       nonarom_chk;
    logic [1:0]    pi_chk;
    settle_t       arom_fin;
    settle_t       nonarom_fin;
    logic          s1_emits;
    logic          s1_fire;
    logic          bond_accept;

    assign item_in.present   = bond_present;
    assign item_in.order     = bond_order;
    assign item_in.in_ring   = bond_in_ring;
    assign item_in.marked    = bond_marked_aromatic;
    assign item_in.group     = grp_t'(atom_group);
    assign item_in.hyd       = implicit_hydrogens;
    assign item_in.chg       = formal_charge;
    assign item_in.last_bond = last_bond_of_atom;
    assign item_in.last_atom = last_atom_of_ring;

    assign s1_emits    = item_reg.last_bond && item_reg.last_atom;
    assign s1_fire     = s1_valid_reg && (!s1_emits || !out_valid_reg || !verdict_stall);
    assign bond_stall  = s1_valid_reg && !s1_fire;
    assign bond_accept = bond_valid && !bond_stall;

    rac_count u_count (
        .item      (item_reg),
        .cnt       (cnt_reg),
        .cnt_upd   (cnt_upd),
        .bad_order (bad_order)
    );

    rac_rules u_rules (
        .cnt     (cnt_upd),
        .group   (item_reg.group),
        .hyd     (item_reg.hyd),
        .chg     (item_reg.chg),
        .verdict (verdict)
    );

    always_comb
    begin
        arom_chk    = (bad_order && (arom_reg == SETTLE_OPEN)) ? SETTLE_FALSE : arom_reg;
        nonarom_chk = (bad_order && (nonarom_reg == SETTLE_OPEN)) ? SETTLE_FALSE
                                                                   : nonarom_reg;
        arom_fin    = arom_chk;
        nonarom_fin = nonarom_chk;
        pi_chk      = pi_reg;
        if (item_reg.last_bond)
        begin
            if (arom_chk == SETTLE_OPEN)
            begin
                if (verdict.pi_ok)
                begin
                    pi_chk = (pi_reg + verdict.pi) & PI_MASK;
                end
                else
                begin
                    arom_fin = SETTLE_FALSE;
                end
            end
            if ((nonarom_chk == SETTLE_OPEN) && verdict.rules_out)
            begin
                nonarom_fin = SETTLE_TRUE;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = bond_stall ? s1_valid_reg : bond_valid;
        cnt_next      = cnt_reg;
        pi_next       = pi_reg;
        arom_next     = arom_reg;
        nonarom_next  = nonarom_reg;
        if (s1_fire)
        begin
            if (s1_emits)
            begin
                cnt_next     = '0;
                pi_next      = 2'd0;
                arom_next    = SETTLE_OPEN;
                nonarom_next = SETTLE_OPEN;
            end
            else
            begin
                cnt_next     = item_reg.last_bond ? '0 : cnt_upd;
                pi_next      = pi_chk;
                arom_next    = arom_fin;
                nonarom_next = nonarom_fin;
            end
        end
        if (s1_fire && s1_emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (!verdict_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            pi_reg        <= 2'd0;
            arom_reg      <= SETTLE_OPEN;
            nonarom_reg   <= SETTLE_OPEN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            cnt_reg       <= cnt_next;
            pi_reg        <= pi_next;
            arom_reg      <= arom_next;
            nonarom_reg   <= nonarom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bond_accept)
        begin
            item_reg <= item_in;
        end
        if (s1_fire && s1_emits)
        begin
            arom_out_reg    <= (arom_fin == SETTLE_OPEN) && (pi_chk == 2'd2);
            nonarom_out_reg <= (nonarom_fin == SETTLE_TRUE);
        end
    end

    assign verdict_valid   = out_valid_reg;
    assign is_aromatic     = arom_out_reg;
    assign is_not_aromatic = nonarom_out_reg;

    `RAC_ASSERT(a_arom_never_true, arom_reg != SETTLE_TRUE)
    `RAC_ASSERT(a_stall_needs_item, !bond_stall || (s1_valid_reg && s1_emits && out_valid_reg))
    `RAC_ASSERT_NEXT(a_atom_clears, s1_fire && item_reg.last_bond, cnt_reg == '0)
    `RAC_ASSERT_NEXT(a_ring_reopens, s1_fire && s1_emits,
                     (arom_reg == SETTLE_OPEN) && (nonarom_reg == SETTLE_OPEN) && out_valid_reg)

endmodule
